// ===== rtl/triangle_shape_gradient_macros.svh =====
// assertion macros used by the triangle gradient top level
`ifndef TRIANGLE_SHAPE_GRADIENT_MACROS_SVH
`define TRIANGLE_SHAPE_GRADIENT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define TSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TSG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tsg_pkg.sv =====
// shared widths, codes and types of the triangle gradient block
package tsg_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_W       = 32;

  localparam int EW   = COORD_WIDTH + 1;
  localparam int EMW  = COORD_WIDTH;
  localparam int NW   = 2 * EW;
  localparam int NMW  = NW - 1;
  localparam int NHI  = NMW / 2;
  localparam int NLO  = NMW - NHI;
  localparam int SQW  = 2 * NMW;
  localparam int DENW = SQW + 2;
  localparam int GW   = NMW + EMW + 2;
  localparam int GMW  = GW - 1;
  localparam int SH   = 2 * FRAC_BITS + 1;
  localparam int D2W  = DENW + 1;
  localparam int QB   = OUT_W + 1;
  localparam int RW   = D2W + QB;

  localparam int FRONT_STAGES = 6;
  localparam int LANE_STAGES  = QB + 6;

  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_DIM_MODE = '0;

  localparam int DIM_W = 2;
  localparam logic [DIM_W-1:0] DIM_PLANAR = 2'd2;
  localparam logic [DIM_W-1:0] DIM_RESET  = 2'd3;

  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;

  localparam logic [OUT_W-1:0] GRAD_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] GRAD_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [EW-1:0]          diff_t;
  typedef logic signed [NW-1:0]          norm_t;
  typedef logic        [DENW-1:0]        den_t;
  typedef logic signed [OUT_W-1:0]       grad_t;

  typedef struct packed {
    logic [1:0] corner;
    logic       last;
    logic       planar;
    logic       degen;
  } ctl_t;

endpackage

// ===== rtl/tsg_front.sv =====
// per-triangle front pipeline: edges, normal and squared normal length
module tsg_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  logic            planar_i,
  input  tsg_pkg::coord_t p_i [3][3],
  output logic            out_v,
  output logic            planar_o,
  output tsg_pkg::coord_t p_o [3][3],
  output tsg_pkg::norm_t  n_o [3],
  output tsg_pkg::den_t   den_o
);

  logic [tsg_pkg::FRONT_STAGES-1:0] v_r;
  logic [tsg_pkg::FRONT_STAGES-1:0] pl_r;
  tsg_pkg::coord_t p_r [tsg_pkg::FRONT_STAGES][3][3];
  tsg_pkg::coord_t pz  [3][3];

  tsg_pkg::diff_t d01_r [3];
  tsg_pkg::diff_t d02_r [3];
  tsg_pkg::norm_t pr_r  [6];
  tsg_pkg::norm_t n_r   [4][3];
  logic [tsg_pkg::NW-1:0] nm [3];
  logic [2*tsg_pkg::NHI-1:0]         hh_r [3];
  logic [tsg_pkg::NHI+tsg_pkg::NLO-1:0] hl_r [3];
  logic [2*tsg_pkg::NLO-1:0]         ll_r [3];
  logic [tsg_pkg::SQW-1:0]           sq_r [3];
  tsg_pkg::den_t den_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        pz[k][c] = (planar_i && c == 2) ? '0 : p_i[k][c];
      end
    end
    for (int c = 0; c < 3; c++) begin
      nm[c] = n_r[0][c][tsg_pkg::NW-1] ? -n_r[0][c] : n_r[0][c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[tsg_pkg::FRONT_STAGES-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= {pl_r[tsg_pkg::FRONT_STAGES-2:0], planar_i};
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          p_r[0][k][c] <= pz[k][c];
          for (int s = 1; s < tsg_pkg::FRONT_STAGES; s++) begin
            p_r[s][k][c] <= p_r[s-1][k][c];
          end
        end
      end
      for (int c = 0; c < 3; c++) begin
        d01_r[c] <= {pz[1][c][tsg_pkg::COORD_WIDTH-1], pz[1][c]}
                  - {pz[0][c][tsg_pkg::COORD_WIDTH-1], pz[0][c]};
        d02_r[c] <= {pz[2][c][tsg_pkg::COORD_WIDTH-1], pz[2][c]}
                  - {pz[0][c][tsg_pkg::COORD_WIDTH-1], pz[0][c]};
      end
      // cross product terms of the edges d01 and d02
      pr_r[0] <= d01_r[1] * d02_r[2];
      pr_r[1] <= d01_r[2] * d02_r[1];
      pr_r[2] <= d01_r[2] * d02_r[0];
      pr_r[3] <= d01_r[0] * d02_r[2];
      pr_r[4] <= d01_r[0] * d02_r[1];
      pr_r[5] <= d01_r[1] * d02_r[0];
      for (int c = 0; c < 3; c++) begin
        n_r[0][c] <= pr_r[2*c] - pr_r[2*c+1];
        for (int s = 1; s < 4; s++) begin
          n_r[s][c] <= n_r[s-1][c];
        end
        // squares split into half-width partial products
        hh_r[c] <= nm[c][tsg_pkg::NMW-1:tsg_pkg::NLO] * nm[c][tsg_pkg::NMW-1:tsg_pkg::NLO];
        hl_r[c] <= nm[c][tsg_pkg::NMW-1:tsg_pkg::NLO] * nm[c][tsg_pkg::NLO-1:0];
        ll_r[c] <= nm[c][tsg_pkg::NLO-1:0] * nm[c][tsg_pkg::NLO-1:0];
        sq_r[c] <= (tsg_pkg::SQW'(hh_r[c]) << (2*tsg_pkg::NLO))
                 + (tsg_pkg::SQW'(hl_r[c]) << (tsg_pkg::NLO+1))
                 + tsg_pkg::SQW'(ll_r[c]);
      end
      den_r <= tsg_pkg::DENW'(sq_r[0]) + tsg_pkg::DENW'(sq_r[1])
             + tsg_pkg::DENW'(sq_r[2]);
    end
  end

  assign out_v    = v_r[tsg_pkg::FRONT_STAGES-1];
  assign planar_o = pl_r[tsg_pkg::FRONT_STAGES-1];
  assign den_o    = den_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        p_o[k][c] = p_r[tsg_pkg::FRONT_STAGES-1][k][c];
      end
    end
    for (int c = 0; c < 3; c++) begin
      n_o[c] = n_r[3][c];
    end
  end

endmodule

// ===== rtl/tsg_lane.sv =====
// one gradient component lane: cross term, scaling and pipelined division
module tsg_lane (
  input  logic           clk,
  input  logic           en,
  input  tsg_pkg::norm_t n_a,
  input  tsg_pkg::diff_t e_a,
  input  tsg_pkg::norm_t n_b,
  input  tsg_pkg::diff_t e_b,
  input  tsg_pkg::den_t  den_i,
  output tsg_pkg::grad_t grad_o,
  output logic           sat_o
);

  localparam int PHW = tsg_pkg::NHI + tsg_pkg::EMW;
  localparam int PLW = tsg_pkg::NLO + tsg_pkg::EMW;
  localparam int QB  = tsg_pkg::QB;

  logic [tsg_pkg::NW-1:0] nam, nbm;
  logic [tsg_pkg::EW-1:0] eam, ebm;
  logic [PHW-1:0] pah_r, pbh_r;
  logic [PLW-1:0] pal_r, pbl_r;
  logic sa_r, sb_r;
  tsg_pkg::den_t den1_r, den2_r, den3_r;
  logic [tsg_pkg::GW-1:0] ta, tb, gm;
  logic signed [tsg_pkg::GW-1:0] ta_r, tb_r, g_r;
  logic [tsg_pkg::RW-1:0]  rem4_r;
  logic [tsg_pkg::D2W-1:0] d2_4_r;
  logic neg4_r;

  logic [tsg_pkg::RW-1:0]  rem_r [QB+1];
  logic [tsg_pkg::D2W-1:0] d2_r  [QB+1];
  logic [QB-1:0]           q_r   [QB+1];
  logic                    neg_r [QB+1];
  logic                    pre_r [QB+1];

  logic [tsg_pkg::OUT_W-1:0] mag;
  logic big, sat_pos, sat_neg;
  tsg_pkg::grad_t grad_r;
  logic sat_r;

  always_comb begin
    nam = n_a[tsg_pkg::NW-1] ? -n_a : n_a;
    nbm = n_b[tsg_pkg::NW-1] ? -n_b : n_b;
    eam = e_a[tsg_pkg::EW-1] ? -e_a : e_a;
    ebm = e_b[tsg_pkg::EW-1] ? -e_b : e_b;
    ta  = (tsg_pkg::GW'(pah_r) << tsg_pkg::NLO) + tsg_pkg::GW'(pal_r);
    tb  = (tsg_pkg::GW'(pbh_r) << tsg_pkg::NLO) + tsg_pkg::GW'(pbl_r);
    gm  = g_r[tsg_pkg::GW-1] ? -g_r : g_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pah_r  <= nam[tsg_pkg::NMW-1:tsg_pkg::NLO] * eam[tsg_pkg::EMW-1:0];
      pal_r  <= nam[tsg_pkg::NLO-1:0] * eam[tsg_pkg::EMW-1:0];
      pbh_r  <= nbm[tsg_pkg::NMW-1:tsg_pkg::NLO] * ebm[tsg_pkg::EMW-1:0];
      pbl_r  <= nbm[tsg_pkg::NLO-1:0] * ebm[tsg_pkg::EMW-1:0];
      sa_r   <= n_a[tsg_pkg::NW-1] ^ e_a[tsg_pkg::EW-1];
      sb_r   <= n_b[tsg_pkg::NW-1] ^ e_b[tsg_pkg::EW-1];
      den1_r <= den_i;
      ta_r   <= sa_r ? -ta : ta;
      tb_r   <= sb_r ? -tb : tb;
      den2_r <= den1_r;
      g_r    <= ta_r - tb_r;
      den3_r <= den2_r;
      // numerator scaled up, half divisor added for rounding
      rem4_r <= (tsg_pkg::RW'(gm[tsg_pkg::GMW-1:0]) << tsg_pkg::SH)
              + tsg_pkg::RW'(den3_r);
      d2_4_r <= {den3_r, 1'b0};
      neg4_r <= g_r[tsg_pkg::GW-1];
      rem_r[0] <= rem4_r;
      d2_r[0]  <= d2_4_r;
      q_r[0]   <= '0;
      neg_r[0] <= neg4_r;
      pre_r[0] <= rem4_r >= (tsg_pkg::RW'(d2_4_r) << QB);
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int B = QB - 1 - j;
    logic [tsg_pkg::RW-1:0] dsh;
    logic ge;
    assign dsh = tsg_pkg::RW'(d2_r[j]) << B;
    assign ge  = rem_r[j] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? rem_r[j] - dsh : rem_r[j];
        d2_r[j+1]  <= d2_r[j];
        q_r[j+1]   <= q_r[j] | (QB'(ge) << B);
        neg_r[j+1] <= neg_r[j];
        pre_r[j+1] <= pre_r[j];
      end
    end
  end

  always_comb begin
    mag     = q_r[QB][tsg_pkg::OUT_W-1:0];
    big     = pre_r[QB] || q_r[QB][QB-1];
    sat_pos = big || mag[tsg_pkg::OUT_W-1];
    sat_neg = big || (mag[tsg_pkg::OUT_W-1] && (|mag[tsg_pkg::OUT_W-2:0]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[QB]) begin
        grad_r <= sat_neg ? tsg_pkg::GRAD_MIN : -mag;
        sat_r  <= sat_neg;
      end else begin
        grad_r <= sat_pos ? tsg_pkg::GRAD_MAX : mag;
        sat_r  <= sat_pos;
      end
    end
  end

  assign grad_o = grad_r;
  assign sat_o  = sat_r;

endmodule

// ===== rtl/tsg_merge.sv =====
// merge of the three lanes into one result word, output register
module tsg_merge (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_i,
  input  tsg_pkg::ctl_t   ctl_i,
  input  tsg_pkg::grad_t  grad_i [3],
  input  logic            sat_i  [3],
  output logic            out_valid,
  output logic [1:0]      out_corner,
  output tsg_pkg::grad_t  out_grad_x,
  output tsg_pkg::grad_t  out_grad_y,
  output tsg_pkg::grad_t  out_grad_z,
  output logic            out_degenerate,
  output logic            out_saturated,
  output logic            out_last
);

  logic           valid_r;
  tsg_pkg::grad_t gsel  [3];
  logic           sflag [3];
  tsg_pkg::grad_t grad_r [3];
  logic           sat_r, degen_r, last_r;
  logic [1:0]     corner_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (ctl_i.planar && c == 2) begin
        gsel[c]  = '0;
        sflag[c] = 1'b0;
      end else begin
        gsel[c]  = ctl_i.degen ? tsg_pkg::GRAD_MAX : grad_i[c];
        sflag[c] = ctl_i.degen || sat_i[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        grad_r[c] <= gsel[c];
      end
      sat_r    <= sflag[0] || sflag[1] || sflag[2];
      degen_r  <= ctl_i.degen;
      last_r   <= ctl_i.last;
      corner_r <= ctl_i.corner;
    end
  end

  assign out_valid      = valid_r;
  assign out_corner     = corner_r;
  assign out_grad_x     = grad_r[0];
  assign out_grad_y     = grad_r[1];
  assign out_grad_z     = grad_r[2];
  assign out_degenerate = degen_r;
  assign out_saturated  = sat_r;
  assign out_last       = last_r;

endmodule

// ===== rtl/triangle_shape_gradient.sv =====
// top level of the triangle shape function gradient block
// input spacing: the three corners of a triangle share the lanes, so the next triangle waits out a gap
// corners follow back to back while the output is not stalled; a stalled output freezes the whole pipeline
// reset: synchronous active low, clears valids and sequencer, dim_mode back to 3
module triangle_shape_gradient (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tsg_pkg::coord_t               in_v0_x,
  input  tsg_pkg::coord_t               in_v0_y,
  input  tsg_pkg::coord_t               in_v0_z,
  input  tsg_pkg::coord_t               in_v1_x,
  input  tsg_pkg::coord_t               in_v1_y,
  input  tsg_pkg::coord_t               in_v1_z,
  input  tsg_pkg::coord_t               in_v2_x,
  input  tsg_pkg::coord_t               in_v2_y,
  input  tsg_pkg::coord_t               in_v2_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_corner,
  output tsg_pkg::grad_t                out_grad_x,
  output tsg_pkg::grad_t                out_grad_y,
  output tsg_pkg::grad_t                out_grad_z,
  output logic                          out_degenerate,
  output logic                          out_saturated,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsg_pkg::ADDR_W-1:0]    paddr,
  input  logic [tsg_pkg::DATA_W-1:0]    pwdata,
  output logic [tsg_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  `include "triangle_shape_gradient_macros.svh"

  localparam int LS = tsg_pkg::LANE_STAGES;

  logic en;
  logic [tsg_pkg::DIM_W-1:0] dim_r;
  logic sel_dim;

  logic            hold_v_r;
  tsg_pkg::coord_t hold_p_r [3][3];
  logic [1:0]      gap_r;
  logic            take;

  logic            front_v, front_planar;
  tsg_pkg::coord_t front_p [3][3];
  tsg_pkg::norm_t  front_n [3];
  tsg_pkg::den_t   front_den;

  tsg_pkg::coord_t it_p_r [3][3];
  tsg_pkg::norm_t  it_n_r [3];
  tsg_pkg::den_t   it_den_r;
  logic            it_planar_r;
  logic            busy_r;
  logic [1:0]      cnt_r;

  tsg_pkg::diff_t  e_nxt [3];
  logic            li_v_r;
  tsg_pkg::diff_t  li_e_r [3];
  tsg_pkg::norm_t  li_n_r [3];
  tsg_pkg::den_t   li_den_r;
  tsg_pkg::ctl_t   li_ctl_r;

  logic            cp_v_r   [LS];
  tsg_pkg::ctl_t   cp_ctl_r [LS];

  tsg_pkg::grad_t  lane_g [3];
  logic            lane_s [3];

  // configuration port
  assign pready  = 1'b1;
  assign sel_dim = paddr[tsg_pkg::ADDR_W-1:2] == tsg_pkg::REG_DIM_MODE;
  assign prdata  = sel_dim ? tsg_pkg::DATA_W'(dim_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= tsg_pkg::DIM_RESET;
    end else if (psel && penable && pwrite && sel_dim) begin
      dim_r <= pwdata[tsg_pkg::DIM_W-1:0];
    end
  end

  assign en       = !out_valid || out_ready;
  assign take     = hold_v_r && en && (gap_r == 2'd0);
  assign in_ready = !hold_v_r || take;

  // input holding word and spacing of triangles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      gap_r    <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        hold_v_r <= 1'b1;
      end else if (take) begin
        hold_v_r <= 1'b0;
      end
      if (take) begin
        gap_r <= 2'd2;
      end else if (en && gap_r != 2'd0) begin
        gap_r <= 2'(gap_r - 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_p_r[0][0] <= in_v0_x;
      hold_p_r[0][1] <= in_v0_y;
      hold_p_r[0][2] <= in_v0_z;
      hold_p_r[1][0] <= in_v1_x;
      hold_p_r[1][1] <= in_v1_y;
      hold_p_r[1][2] <= in_v1_z;
      hold_p_r[2][0] <= in_v2_x;
      hold_p_r[2][1] <= in_v2_y;
      hold_p_r[2][2] <= in_v2_z;
    end
  end

  tsg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (take),
    .planar_i (dim_r == tsg_pkg::DIM_PLANAR),
    .p_i      (hold_p_r),
    .out_v    (front_v),
    .planar_o (front_planar),
    .p_o      (front_p),
    .n_o      (front_n),
    .den_o    (front_den)
  );

  // corner sequencer
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      unique case (cnt_r)
        tsg_pkg::CORNER_0: e_nxt[c] = {it_p_r[2][c][tsg_pkg::COORD_WIDTH-1], it_p_r[2][c]}
                                    - {it_p_r[1][c][tsg_pkg::COORD_WIDTH-1], it_p_r[1][c]};
        tsg_pkg::CORNER_1: e_nxt[c] = {it_p_r[0][c][tsg_pkg::COORD_WIDTH-1], it_p_r[0][c]}
                                    - {it_p_r[2][c][tsg_pkg::COORD_WIDTH-1], it_p_r[2][c]};
        tsg_pkg::CORNER_2: e_nxt[c] = {it_p_r[1][c][tsg_pkg::COORD_WIDTH-1], it_p_r[1][c]}
                                    - {it_p_r[0][c][tsg_pkg::COORD_WIDTH-1], it_p_r[0][c]};
        default:           e_nxt[c] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= tsg_pkg::CORNER_0;
      li_v_r <= 1'b0;
    end else if (en) begin
      li_v_r <= busy_r;
      if (front_v) begin
        busy_r <= 1'b1;
        cnt_r  <= tsg_pkg::CORNER_0;
      end else if (busy_r) begin
        if (cnt_r == tsg_pkg::CORNER_2) begin
          busy_r <= 1'b0;
          cnt_r  <= tsg_pkg::CORNER_0;
        end else begin
          cnt_r <= 2'(cnt_r + 2'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (front_v) begin
        it_p_r      <= front_p;
        it_n_r      <= front_n;
        it_den_r    <= front_den;
        it_planar_r <= front_planar;
      end
      if (busy_r) begin
        li_e_r          <= e_nxt;
        li_n_r          <= it_n_r;
        li_den_r        <= it_den_r;
        li_ctl_r.corner <= cnt_r;
        li_ctl_r.last   <= cnt_r == tsg_pkg::CORNER_2;
        li_ctl_r.planar <= it_planar_r;
        li_ctl_r.degen  <= it_den_r == '0;
      end
    end
  end

  // control words travel beside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LS; s++) begin
        cp_v_r[s] <= 1'b0;
      end
    end else if (en) begin
      cp_v_r[0] <= li_v_r;
      for (int s = 1; s < LS; s++) begin
        cp_v_r[s] <= cp_v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp_ctl_r[0] <= li_ctl_r;
      for (int s = 1; s < LS; s++) begin
        cp_ctl_r[s] <= cp_ctl_r[s-1];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    localparam int C1 = (c + 1) % 3;
    localparam int C2 = (c + 2) % 3;
    tsg_lane u_lane (
      .clk    (clk),
      .en     (en),
      .n_a    (li_n_r[C1]),
      .e_a    (li_e_r[C2]),
      .n_b    (li_n_r[C2]),
      .e_b    (li_e_r[C1]),
      .den_i  (li_den_r),
      .grad_o (lane_g[c]),
      .sat_o  (lane_s[c])
    );
  end

  tsg_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .v_i            (cp_v_r[LS-1]),
    .ctl_i          (cp_ctl_r[LS-1]),
    .grad_i         (lane_g),
    .sat_i          (lane_s),
    .out_valid      (out_valid),
    .out_corner     (out_corner),
    .out_grad_x     (out_grad_x),
    .out_grad_y     (out_grad_y),
    .out_grad_z     (out_grad_z),
    .out_degenerate (out_degenerate),
    .out_saturated  (out_saturated),
    .out_last       (out_last)
  );

  `TSG_ASSERT_NOW(a_seq_free, front_v && en, !busy_r || cnt_r == tsg_pkg::CORNER_2, "triangle reached busy sequencer")
  `TSG_ASSERT_NXT(a_seq_load, front_v && en, busy_r && cnt_r == tsg_pkg::CORNER_0, "sequencer did not start at corner 0")
  `TSG_ASSERT_NOW(a_degen_sat, out_valid && out_degenerate, out_saturated, "degenerate word not flagged saturated")
  `TSG_ASSERT_NOW(a_last_corner, out_valid && out_last, out_corner == tsg_pkg::CORNER_2, "last flag off corner 2")

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the triangle shape gradient block
`timescale 1ns / 100ps

module tb_top;

  typedef logic signed [255:0] wide_t;
  typedef struct packed {
    logic [1:0]     corner;
    tsg_pkg::grad_t gx;
    tsg_pkg::grad_t gy;
    tsg_pkg::grad_t gz;
    logic           degen;
    logic           sat;
    logic           last;
  } grad_word_t;
  typedef struct packed {
    logic              typed;
    logic [8:0][31:0]  v;
  } tri_row_t;

  localparam int LIMIT   = 600000;
  localparam int LATENCY = 60;

  logic clk, rst_n;
  logic in_valid, in_ready;
  tsg_pkg::coord_t in_v [9];
  logic out_valid, out_ready;
  logic [1:0] out_corner;
  tsg_pkg::grad_t out_grad_x, out_grad_y, out_grad_z;
  logic out_degenerate, out_saturated, out_last;
  logic psel, penable, pwrite, pready;
  logic [tsg_pkg::ADDR_W-1:0] paddr;
  logic [tsg_pkg::DATA_W-1:0] pwdata, prdata;

  grad_word_t grad_q [$];
  logic [1:0] dim_shadow;
  int errors = 0;
  int cycles = 0;
  int n_tri = 0;
  int n_words = 0;
  int n_degen = 0;
  int n_sat = 0;
  int send_idle, recv_idle;
  logic hold_req;
  tri_row_t rows [12];

  triangle_shape_gradient uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_v0_x(in_v[0]), .in_v0_y(in_v[1]), .in_v0_z(in_v[2]),
    .in_v1_x(in_v[3]), .in_v1_y(in_v[4]), .in_v1_z(in_v[5]),
    .in_v2_x(in_v[6]), .in_v2_y(in_v[7]), .in_v2_z(in_v[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_corner(out_corner), .out_grad_x(out_grad_x), .out_grad_y(out_grad_y),
    .out_grad_z(out_grad_z), .out_degenerate(out_degenerate),
    .out_saturated(out_saturated), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic void cross3(input wide_t a [3], input wide_t b [3],
                                 output wide_t r [3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // round to nearest, ties away from zero, then clip to 32 bits
  function automatic tsg_pkg::grad_t scaled_quot(input wide_t num, input wide_t den,
                                                 inout logic sat);
    wide_t a, q;
    logic neg;
    neg = num < 0;
    a = ((neg ? -num : num) <<< (2 * tsg_pkg::FRAC_BITS + 1)) + den;
    q = a / (den <<< 1);
    if (!neg) begin
      if (q > 64'sd2147483647) begin
        sat = 1'b1;
        return tsg_pkg::GRAD_MAX;
      end
      return tsg_pkg::grad_t'(q[31:0]);
    end
    if (q > 64'sd2147483648) begin
      sat = 1'b1;
      q = 64'sd2147483648;
    end
    return tsg_pkg::grad_t'(-q);
  endfunction

  function automatic void predict_gradients(input tsg_pkg::coord_t c [9]);
    wide_t p [3][3];
    wide_t e01 [3], e02 [3], n [3], e [3], g [3];
    wide_t den;
    logic planar, degen, sat;
    grad_word_t w;
    tsg_pkg::grad_t comp [3];
    planar = (dim_shadow == tsg_pkg::DIM_PLANAR);
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++)
        p[k][j] = (planar && j == 2) ? wide_t'(0) : wide_t'(c[k*3+j]);
    for (int j = 0; j < 3; j++) begin
      e01[j] = p[1][j] - p[0][j];
      e02[j] = p[2][j] - p[0][j];
    end
    cross3(e01, e02, n);
    den = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    degen = (den == 0);
    for (int k = 0; k < 3; k++) begin
      sat = 1'b0;
      for (int j = 0; j < 3; j++) e[j] = p[(k+2)%3][j] - p[(k+1)%3][j];
      cross3(n, e, g);
      for (int j = 0; j < 3; j++) begin
        if (planar && j == 2) comp[j] = '0;
        else if (degen) begin
          comp[j] = tsg_pkg::GRAD_MAX;
          sat = 1'b1;
        end else comp[j] = scaled_quot(g[j], den, sat);
      end
      w = '{corner: k[1:0], gx: comp[0], gy: comp[1], gz: comp[2],
            degen: degen, sat: sat, last: (k == 2)};
      grad_q.push_back(w);
    end
  endfunction

  task automatic cfg_write(input logic [tsg_pkg::ADDR_W-1:0] addr,
                           input logic [tsg_pkg::DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_tri(input tsg_pkg::coord_t c [9], input logic typed);
    grad_word_t w;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    for (int j = 0; j < 9; j++) in_v[j] <= c[j];
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      // zero area: every component pinned to the positive rail, z cleared in planar mode
      for (int k = 0; k < 3; k++) begin
        w = '{corner: k[1:0], gx: tsg_pkg::GRAD_MAX, gy: tsg_pkg::GRAD_MAX,
              gz: (dim_shadow == tsg_pkg::DIM_PLANAR) ? tsg_pkg::grad_t'(0)
                                                      : tsg_pkg::GRAD_MAX,
              degen: 1'b1, sat: 1'b1, last: (k == 2)};
        grad_q.push_back(w);
      end
    end else predict_gradients(c);
    n_tri++;
    @(negedge clk);
  endtask

  function automatic tsg_pkg::coord_t rand_coord(input int kind);
    case (kind)
      0: return tsg_pkg::coord_t'($urandom);
      1: return tsg_pkg::coord_t'($urandom_range(0, 2097151)) - 32'sd1048576;
      default: return tsg_pkg::coord_t'($urandom_range(0, 255)) - 32'sd128;
    endcase
  endfunction

  task automatic send_random();
    tsg_pkg::coord_t c [9];
    int kind, shape;
    kind = $urandom_range(0, 9);
    kind = (kind < 3) ? 0 : (kind < 8) ? 1 : 2;
    for (int j = 0; j < 9; j++) c[j] = rand_coord(kind);
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      for (int j = 0; j < 3; j++) c[6+j] = c[3+j];
    end else if (shape == 1) begin
      for (int j = 0; j < 3; j++) c[6+j] = c[j] + (c[3+j] - c[j]) * 2;
    end
    send_tri(c, 1'b0);
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) hold_left = 400;
      if (hold_left > 1) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (hold_left == 1) hold_left = -1;
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    grad_word_t w;
    if (rst_n && out_valid && out_ready) begin
      n_words++;
      if (grad_q.size() == 0) begin
        $display("%0t: unexpected word corner=%0d", $time, out_corner);
        errors++;
      end else begin
        w = grad_q.pop_front();
        if (out_degenerate) n_degen++;
        if (out_saturated) n_sat++;
        if ({out_corner, out_grad_x, out_grad_y, out_grad_z, out_degenerate,
             out_saturated, out_last} !== w) begin
          $display("%0t: mismatch exp c=%0d x=%h y=%h z=%h d=%b s=%b l=%b",
                   $time, w.corner, w.gx, w.gy, w.gz, w.degen, w.sat, w.last);
          $display("%0t:          got c=%0d x=%h y=%h z=%h d=%b s=%b l=%b",
                   $time, out_corner, out_grad_x, out_grad_y, out_grad_z,
                   out_degenerate, out_saturated, out_last);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (grad_q.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  initial begin
    tsg_pkg::coord_t c [9];
    logic [1:0] seg_dim [6];
    seg_dim = '{tsg_pkg::DIM_RESET, tsg_pkg::DIM_PLANAR, 2'd0, tsg_pkg::DIM_RESET,
                tsg_pkg::DIM_PLANAR, 2'd1};
    hold_req = 1'b0; send_idle = 7; recv_idle = 78;
    rst_n = 1'b0; in_valid = 1'b0;
    for (int j = 0; j < 9; j++) in_v[j] = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    dim_shadow = tsg_pkg::DIM_RESET;
    rows[0]  = '{1'b1, {9{32'h0}}};
    rows[1]  = '{1'b1, {9{32'h7fffffff}}};
    rows[2]  = '{1'b1, {9{32'h80000000}}};
    rows[3]  = '{1'b1, {32'h20000, 32'h20000, 32'h20000, 32'h10000, 32'h10000,
                        32'h10000, 32'h0, 32'h0, 32'h0}};
    rows[4]  = '{1'b0, {32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000,
                        32'h0, 32'h0, 32'h0}};
    rows[5]  = '{1'b0, {32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0,
                        32'h0, 32'h0, 32'h0}};
    rows[6]  = '{1'b0, {32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0}};
    rows[7]  = '{1'b0, {32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                        32'h80000000}};
    rows[8]  = '{1'b0, {32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff}};
    rows[9]  = '{1'b0, {32'h3000, 32'hfffe8000, 32'h28000, 32'h1c000, 32'h4000,
                        32'hffff0000, 32'h5000, 32'h6000, 32'h7000}};
    rows[10] = '{1'b0, {32'hffff0000, 32'h0, 32'h7fffffff, 32'h0, 32'hffff0000,
                        32'h80000000, 32'h0, 32'h0, 32'h0}};
    rows[11] = '{1'b0, {32'h1, 32'h7fffffff, 32'hffffffff, 32'h10000, 32'h80000000,
                        32'hfffffffe, 32'h40000000, 32'hc0000000, 32'h1}};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int s = 0; s < 6; s++) begin
      send_idle = (s < 2) ? 7 : (s < 4) ? 78 : 0;
      recv_idle = (s < 2) ? 78 : (s < 4) ? 7 : 0;
      if (s > 0) begin
        drain();
        cfg_write(tsg_pkg::ADDR_W'(tsg_pkg::REG_DIM_MODE) << 2,
                  tsg_pkg::DATA_W'(seg_dim[s]));
        dim_shadow = seg_dim[s];
      end
      if (s == 0 || s == 1) begin
        for (int r = 0; r < 12; r++) begin
          for (int j = 0; j < 9; j++) c[j] = rows[r].v[8-j];
          send_tri(c, rows[r].typed);
        end
      end
      if (s == 5) hold_req = 1'b1;
      repeat (42) send_random();
    end
    drain();
    $display("covered %0d triangles, %0d gradient words over planar and spatial modes",
             n_tri, n_words);
    $display("%0d degenerate and %0d saturated words seen, %0d mismatches",
             n_degen, n_sat, errors);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tsg_pkg.sv
rtl/tsg_front.sv
rtl/tsg_lane.sv
rtl/tsg_merge.sv
rtl/triangle_shape_gradient.sv
dv/tb_top.sv
